// ===== design/lfu_pkg.sv =====
package lfu_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int CAP_W   = 5;
  localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int WORD_W  = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET  = 5'd16;
  localparam logic [WORD_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] SAT32      = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] NEW_USES   = 32'd1;
  localparam logic [WORD_W-1:0] SET_READ   = 32'd0;

  localparam logic ACT_GET = 1'b0;
  localparam logic ACT_SET = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] data;
    logic [WORD_W-1:0] uses;
    logic [WORD_W-1:0] stamp;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic             clr;
    logic             vld;
    logic [IDX_W-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [WORD_W-1:0] hit_data;
    logic [WORD_W-1:0] hit_uses;
    logic              vic_found;
    logic [IDX_W-1:0]  vic_idx;
  } scan_res_t;

  function automatic logic [WORD_W-1:0] sat_inc(input logic [WORD_W-1:0] x);
    sat_inc = (x == SAT32) ? x : x + WORD_W'(1);
  endfunction

endpackage

// ===== design/lfu_cache_table_unit.sv =====
// Key-value table with least-frequently-used replacement (oldest stamp, then
// lowest slot, break ties). Raise start for one cycle while busy is low; the
// request is taken at that edge. Every request reads all ENTRIES slots of the
// slot memory, one per cycle through its single read port, then writes the
// touched slot back; busy stays high throughout, so a new request can start
// only once busy is low again. The result is shown for exactly one cycle with
// out_valid high, in the same cycle that busy falls; it cannot be held off, so
// capture it then. The user must write capacity through the cfg port only
// while the block is idle; the block itself does not enforce it.
module lfu_cache_table_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_action,
  input  logic signed [31:0]            in_key,
  input  logic signed [31:0]            in_value,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic signed [31:0]            out_read_value,
  output logic                          out_evicted,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lfu_pkg::CAP_W-1:0]     cfg_capacity
);

  lfu_pkg::state_t                 state_r;
  lfu_pkg::state_t                 state_nxt;
  logic [lfu_pkg::IDX_W-1:0]       addr_r;
  logic                            pend_r;
  logic [lfu_pkg::IDX_W-1:0]       pend_idx_r;
  logic [lfu_pkg::ENTRIES-1:0]     valid_r;
  logic [lfu_pkg::CNT_W-1:0]       occ_r;
  logic [lfu_pkg::WORD_W-1:0]      clock_r;
  logic [lfu_pkg::CAP_W-1:0]       cap_r;
  logic                            req_act_r;
  logic [lfu_pkg::WORD_W-1:0]      req_key_r;
  logic [lfu_pkg::WORD_W-1:0]      req_val_r;
  logic                            out_valid_r;
  logic                            out_hit_r;
  logic [lfu_pkg::WORD_W-1:0]      out_read_r;
  logic                            out_evicted_r;

  logic                            accept;
  logic                            last_addr;
  lfu_pkg::scan_ctl_t              scan_ctl;
  lfu_pkg::scan_res_t              scan_res;
  lfu_pkg::entry_t                 rd_entry;
  logic [lfu_pkg::ENTRY_W-1:0]     rd_word;

  logic                            free_found;
  logic [lfu_pkg::IDX_W-1:0]       free_idx;
  logic [lfu_pkg::CMP_W-1:0]       eff_cap;
  logic                            below_cap;

  logic                            wr_en;
  logic [lfu_pkg::IDX_W-1:0]       wr_idx;
  lfu_pkg::entry_t                 wr_entry;
  logic                            wr_fill;
  logic                            res_hit;
  logic [lfu_pkg::WORD_W-1:0]      res_read;
  logic                            res_evicted;

  assign accept    = start && !busy;
  assign last_addr = (addr_r == lfu_pkg::IDX_W'(lfu_pkg::ENTRIES - 1));
  assign cfg_ready = 1'b1;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lfu_pkg::ST_IDLE:  if (start) state_nxt = lfu_pkg::ST_SCAN;
      lfu_pkg::ST_SCAN:  if (last_addr) state_nxt = lfu_pkg::ST_LAST;
      lfu_pkg::ST_LAST:  state_nxt = lfu_pkg::ST_WRITE;
      lfu_pkg::ST_WRITE: state_nxt = lfu_pkg::ST_IDLE;
      default:           state_nxt = lfu_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy = 1'b1;
    case (state_r)
      lfu_pkg::ST_IDLE:  busy = 1'b0;
      lfu_pkg::ST_SCAN,
      lfu_pkg::ST_LAST,
      lfu_pkg::ST_WRITE: busy = 1'b1;
      default:           busy = 1'b1;
    endcase
  end

  // Read data arrives in the cycle after its address; empty slots are skipped.
  assign scan_ctl.clr = accept;
  assign scan_ctl.vld = pend_r && valid_r[pend_idx_r];
  assign scan_ctl.idx = pend_idx_r;
  assign rd_entry     = lfu_pkg::entry_t'(rd_word);

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = lfu_pkg::ENTRIES - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = lfu_pkg::IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = lfu_pkg::CMP_W'(1);
    end else if (lfu_pkg::CMP_W'(cap_r) > lfu_pkg::CMP_W'(lfu_pkg::ENTRIES)) begin
      eff_cap = lfu_pkg::CMP_W'(lfu_pkg::ENTRIES);
    end else begin
      eff_cap = lfu_pkg::CMP_W'(cap_r);
    end
  end

  assign below_cap = (lfu_pkg::CMP_W'(occ_r) < eff_cap);

  // Write-back decision, valid during the write state.
  always_comb begin
    wr_en          = 1'b0;
    wr_fill        = 1'b0;
    wr_idx         = scan_res.hit_idx;
    wr_entry.key   = req_key_r;
    wr_entry.data  = req_val_r;
    wr_entry.uses  = lfu_pkg::NEW_USES;
    wr_entry.stamp = clock_r;
    res_hit        = scan_res.hit;
    res_read       = lfu_pkg::SET_READ;
    res_evicted    = 1'b0;
    if (req_act_r == lfu_pkg::ACT_GET) begin
      if (scan_res.hit) begin
        wr_en         = 1'b1;
        wr_entry.data = scan_res.hit_data;
        wr_entry.uses = lfu_pkg::sat_inc(scan_res.hit_uses);
        res_read      = scan_res.hit_data;
      end else begin
        res_read = lfu_pkg::MISS_VALUE;
      end
    end else if (scan_res.hit) begin
      wr_en         = 1'b1;
      wr_entry.uses = lfu_pkg::sat_inc(scan_res.hit_uses);
    end else if (below_cap && free_found) begin
      wr_en   = 1'b1;
      wr_fill = 1'b1;
      wr_idx  = free_idx;
    end else if (scan_res.vic_found) begin
      wr_en       = 1'b1;
      wr_idx      = scan_res.vic_idx;
      res_evicted = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lfu_pkg::ST_IDLE;
      pend_r      <= 1'b0;
      valid_r     <= '0;
      occ_r       <= '0;
      clock_r     <= '0;
      cap_r       <= lfu_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= (state_r == lfu_pkg::ST_SCAN);
      out_valid_r <= (state_r == lfu_pkg::ST_WRITE);
      if (cfg_valid && cfg_ready) begin
        cap_r <= cfg_capacity;
      end
      if (state_r == lfu_pkg::ST_WRITE) begin
        clock_r <= lfu_pkg::sat_inc(clock_r);
        if (wr_en) begin
          valid_r[wr_idx] <= 1'b1;
        end
        if (wr_fill) begin
          occ_r <= occ_r + lfu_pkg::CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= addr_r;
    if (accept) begin
      addr_r    <= '0;
      req_act_r <= in_action;
      req_key_r <= in_key;
      req_val_r <= in_value;
    end else if (state_r == lfu_pkg::ST_SCAN && !last_addr) begin
      addr_r <= addr_r + lfu_pkg::IDX_W'(1);
    end
    if (state_r == lfu_pkg::ST_WRITE) begin
      out_hit_r     <= res_hit;
      out_read_r    <= res_read;
      out_evicted_r <= res_evicted;
    end
  end

  lfu_ram #(
    .WIDTH (lfu_pkg::ENTRY_W),
    .DEPTH (lfu_pkg::ENTRIES)
  ) u_slots (
    .clk   (clk),
    .we    (wr_en && (state_r == lfu_pkg::ST_WRITE)),
    .waddr (wr_idx),
    .wdata (wr_entry),
    .raddr (addr_r),
    .rdata (rd_word)
  );

  lfu_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (scan_ctl),
    .entry   (rd_entry),
    .req_key (req_key_r),
    .res     (scan_res)
  );

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_read_value = out_read_r;
  assign out_evicted    = out_evicted_r;

  a_strobe_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == lfu_pkg::ST_WRITE))
    else $error("result strobe without a preceding write-back");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lfu_pkg::CMP_W'(occ_r) <= lfu_pkg::CMP_W'(lfu_pkg::ENTRIES))
    else $error("occupancy above entry count");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy && !out_valid_r)
    else $error("accepted request did not raise busy");

  a_evict_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evicted_r |-> !out_hit_r)
    else $error("eviction reported on a hit");

endmodule

// ===== design/lfu_ram.sv =====
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== design/lfu_scan.sv =====
module lfu_scan (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lfu_pkg::scan_ctl_t             ctl,
  input  lfu_pkg::entry_t                entry,
  input  logic [lfu_pkg::WORD_W-1:0]     req_key,
  output lfu_pkg::scan_res_t             res
);

  logic                          hit_r;
  logic [lfu_pkg::IDX_W-1:0]     hit_idx_r;
  logic [lfu_pkg::WORD_W-1:0]    hit_data_r;
  logic [lfu_pkg::WORD_W-1:0]    hit_uses_r;
  logic                          vic_found_r;
  logic [lfu_pkg::IDX_W-1:0]     vic_idx_r;
  logic [lfu_pkg::WORD_W-1:0]    vic_uses_r;
  logic [lfu_pkg::WORD_W-1:0]    vic_stamp_r;
  logic                          match;
  logic                          better;

  assign match = (entry.key == req_key);

  // Strict compares keep the lowest slot on a full tie.
  assign better = !vic_found_r || (entry.uses < vic_uses_r) ||
                  ((entry.uses == vic_uses_r) && (entry.stamp < vic_stamp_r));

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clr) begin
      hit_r       <= 1'b0;
      vic_found_r <= 1'b0;
    end else if (ctl.vld) begin
      if (match && !hit_r) begin
        hit_r <= 1'b1;
      end
      if (better) begin
        vic_found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.vld) begin
      if (match && !hit_r) begin
        hit_idx_r  <= ctl.idx;
        hit_data_r <= entry.data;
        hit_uses_r <= entry.uses;
      end
      if (better) begin
        vic_idx_r   <= ctl.idx;
        vic_uses_r  <= entry.uses;
        vic_stamp_r <= entry.stamp;
      end
    end
  end

  assign res.hit       = hit_r;
  assign res.hit_idx   = hit_idx_r;
  assign res.hit_data  = hit_data_r;
  assign res.hit_uses  = hit_uses_r;
  assign res.vic_found = vic_found_r;
  assign res.vic_idx   = vic_idx_r;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int SETTLE_CYCLES = lfu_pkg::ENTRIES + 4;
  localparam int TAIL_CYCLES   = 2 * (lfu_pkg::ENTRIES + 3);
  localparam int STALL_LIMIT   = 1000;
  localparam int POOL_DEPTH    = 32;

  localparam logic [lfu_pkg::WORD_W-1:0] INT_MIN = 32'h8000_0000;
  localparam logic [lfu_pkg::WORD_W-1:0] INT_MAX = 32'h7FFF_FFFF;
  localparam logic [lfu_pkg::WORD_W-1:0] ALL_ONE = 32'hFFFF_FFFF;

  typedef enum logic {
    PLAN_REQUEST,
    PLAN_CAPACITY
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t                 kind;
    logic                       action;
    logic [lfu_pkg::WORD_W-1:0] key;
    logic [lfu_pkg::WORD_W-1:0] value;
    logic [lfu_pkg::CAP_W-1:0]  capacity;
  } plan_item_t;

  typedef struct packed {
    logic                       hit;
    logic [lfu_pkg::WORD_W-1:0] read_value;
    logic                       evicted;
  } lookup_reply_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              in_action = lfu_pkg::ACT_GET;
  logic signed [lfu_pkg::WORD_W-1:0] in_key = '0;
  logic signed [lfu_pkg::WORD_W-1:0] in_value = '0;
  logic                              out_valid;
  logic                              out_hit;
  logic signed [lfu_pkg::WORD_W-1:0] out_read_value;
  logic                              out_evicted;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [lfu_pkg::CAP_W-1:0]         cfg_capacity = lfu_pkg::CAP_RESET;

  // Plan of requests and capacity writes, and the replies still owed by the block.
  plan_item_t    request_plan[$];
  lookup_reply_t predicted_replies[$];

  logic [lfu_pkg::WORD_W-1:0] key_pool [POOL_DEPTH];

  // Shadow copy of the table.
  logic                       tbl_valid [lfu_pkg::ENTRIES];
  logic [lfu_pkg::WORD_W-1:0] tbl_key   [lfu_pkg::ENTRIES];
  logic [lfu_pkg::WORD_W-1:0] tbl_data  [lfu_pkg::ENTRIES];
  logic [lfu_pkg::WORD_W-1:0] tbl_uses  [lfu_pkg::ENTRIES];
  logic [lfu_pkg::WORD_W-1:0] tbl_stamp [lfu_pkg::ENTRIES];
  int                         tbl_occupancy;
  logic [lfu_pkg::WORD_W-1:0] tbl_clock;
  logic [lfu_pkg::CAP_W-1:0]  tbl_capacity;

  int settle_cnt  = 0;
  int burst_left  = 0;
  int gap_left    = 0;
  int quiet_cycles = 0;
  int fail_count  = 0;

  lfu_cache_table_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_key         (in_key),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_capacity   (cfg_capacity)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic lookup_reply_t cache_model_access(
      input logic act,
      input logic [lfu_pkg::WORD_W-1:0] k,
      input logic [lfu_pkg::WORD_W-1:0] v);
    lookup_reply_t r;
    int            hit_slot;
    int            target;
    int            cap_eff;
    r.hit        = 1'b0;
    r.read_value = (act == lfu_pkg::ACT_GET) ? lfu_pkg::MISS_VALUE : lfu_pkg::SET_READ;
    r.evicted    = 1'b0;
    hit_slot     = -1;
    target       = -1;
    cap_eff      = int'(tbl_capacity);
    if (cap_eff < 1) cap_eff = 1;
    if (cap_eff > lfu_pkg::ENTRIES) cap_eff = lfu_pkg::ENTRIES;
    for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
      if (hit_slot < 0 && tbl_valid[i] && tbl_key[i] == k) hit_slot = i;
    end
    if (hit_slot >= 0) begin
      r.hit = 1'b1;
      if (act == lfu_pkg::ACT_GET) r.read_value = tbl_data[hit_slot];
      else tbl_data[hit_slot] = v;
      if (tbl_uses[hit_slot] != lfu_pkg::SAT32) tbl_uses[hit_slot] = tbl_uses[hit_slot] + 1;
      tbl_stamp[hit_slot] = tbl_clock;
    end else if (act == lfu_pkg::ACT_SET) begin
      if (tbl_occupancy < cap_eff) begin
        for (int i = lfu_pkg::ENTRIES - 1; i >= 0; i--) begin
          if (!tbl_valid[i]) target = i;
        end
      end
      if (target >= 0) begin
        tbl_occupancy++;
      end else begin
        // Fewest uses first, then the oldest stamp; a strict compare keeps the lowest slot.
        for (int i = 0; i < lfu_pkg::ENTRIES; i++) begin
          if (tbl_valid[i] && (target < 0 || tbl_uses[i] < tbl_uses[target] ||
              (tbl_uses[i] == tbl_uses[target] && tbl_stamp[i] < tbl_stamp[target])))
            target = i;
        end
        if (target >= 0) r.evicted = 1'b1;
      end
      if (target >= 0) begin
        tbl_valid[target] = 1'b1;
        tbl_key[target]   = k;
        tbl_data[target]  = v;
        tbl_uses[target]  = lfu_pkg::NEW_USES;
        tbl_stamp[target] = tbl_clock;
      end
    end
    if (tbl_clock != lfu_pkg::SAT32) tbl_clock = tbl_clock + 1;
    return r;
  endfunction

  task automatic plan_request(input logic act, input logic [lfu_pkg::WORD_W-1:0] k,
                              input logic [lfu_pkg::WORD_W-1:0] v);
    plan_item_t p;
    p.kind     = PLAN_REQUEST;
    p.action   = act;
    p.key      = k;
    p.value    = v;
    p.capacity = '0;
    request_plan.insert(request_plan.size(), p);
  endtask

  task automatic plan_capacity(input logic [lfu_pkg::CAP_W-1:0] c);
    plan_item_t p;
    p.kind     = PLAN_CAPACITY;
    p.action   = lfu_pkg::ACT_GET;
    p.key      = '0;
    p.value    = '0;
    p.capacity = c;
    request_plan.insert(request_plan.size(), p);
  endtask

  // Most keys come from a small pool so that hits and evictions are frequent.
  task automatic plan_random_phase(input logic [lfu_pkg::CAP_W-1:0] c, input int pool_size,
                                   input int count);
    logic [lfu_pkg::WORD_W-1:0] k;
    logic [lfu_pkg::WORD_W-1:0] v;
    logic                       act;
    plan_capacity(c);
    for (int n = 0; n < count; n++) begin
      act = ($urandom_range(0, 99) < 55) ? lfu_pkg::ACT_SET : lfu_pkg::ACT_GET;
      if ($urandom_range(0, 9) < 8) k = key_pool[5'($urandom_range(0, pool_size - 1))];
      else k = $urandom;
      v = $urandom;
      if ($urandom_range(0, 15) == 0) begin
        case ($urandom_range(0, 3))
          0: v = INT_MIN;
          1: v = INT_MAX;
          2: v = '0;
          default: v = ALL_ONE;
        endcase
      end
      plan_request(act, k, v);
    end
  endtask

  always @(posedge clk) begin : drive_requests
    logic       took_req;
    logic       took_cfg;
    logic       nxt_start;
    logic       nxt_cfg;
    logic       load_req;
    logic       load_cfg;
    plan_item_t item;
    took_req  = start && !busy;
    took_cfg  = cfg_valid && cfg_ready;
    load_req  = 1'b0;
    load_cfg  = 1'b0;
    item      = '0;
    if (!rst_n) begin
      for (int i = 0; i < lfu_pkg::ENTRIES; i++) tbl_valid[i] = 1'b0;
      tbl_occupancy = 0;
      tbl_clock     = '0;
      tbl_capacity  = lfu_pkg::CAP_RESET;
      settle_cnt    = 0;
      start        <= 1'b0;
      cfg_valid    <= 1'b0;
    end else begin
      if (took_req)
        predicted_replies.insert(predicted_replies.size(),
                                 cache_model_access(in_action, in_key, in_value));
      if (took_cfg) tbl_capacity = cfg_capacity;
      if (busy || start || out_valid || predicted_replies.size() != 0) settle_cnt = 0;
      else if (settle_cnt < SETTLE_CYCLES) settle_cnt++;
      nxt_start = start && !took_req;
      nxt_cfg   = cfg_valid && !took_cfg;
      if (!nxt_start && !nxt_cfg && request_plan.size() != 0) begin
        if (request_plan[0].kind == PLAN_CAPACITY) begin
          // The capacity only changes once the block has gone quiet.
          if (settle_cnt >= SETTLE_CYCLES) begin
            item     = request_plan.pop_front();
            load_cfg = 1'b1;
            nxt_cfg  = 1'b1;
          end
        end else if (gap_left != 0) begin
          gap_left--;
        end else begin
          item      = request_plan.pop_front();
          load_req  = 1'b1;
          nxt_start = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 6);
            gap_left   = $urandom_range(0, 28);
          end
        end
      end
      start     <= nxt_start;
      cfg_valid <= nxt_cfg;
      if (load_req) begin
        in_action <= item.action;
        in_key    <= item.key;
        in_value  <= item.value;
      end else if (!nxt_start) begin
        in_action <= 1'($urandom_range(0, 1));
        in_key    <= $urandom;
        in_value  <= $urandom;
      end
      if (load_cfg) cfg_capacity <= item.capacity;
      else if (!nxt_cfg) cfg_capacity <= lfu_pkg::CAP_W'($urandom_range(0, 31));
    end
  end

  always @(posedge clk) begin : check_replies
    lookup_reply_t want;
    if (rst_n && out_valid) begin
      if (predicted_replies.size() == 0) begin
        $error("reply with none outstanding: hit=%0b read_value=%0d evicted=%0b",
               out_hit, out_read_value, out_evicted);
        fail_count++;
      end else begin
        want = predicted_replies.pop_front();
        if (out_hit !== want.hit) begin
          $error("out_hit: expected %0b, got %0b", want.hit, out_hit);
          fail_count++;
        end
        if (out_read_value !== want.read_value) begin
          $error("out_read_value: expected %0d, got %0d",
                 $signed(want.read_value), out_read_value);
          fail_count++;
        end
        if (out_evicted !== want.evicted) begin
          $error("out_evicted: expected %0b, got %0b", want.evicted, out_evicted);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : run_test
    int tail;
    key_pool[0] = INT_MIN;
    key_pool[1] = INT_MAX;
    key_pool[2] = '0;
    key_pool[3] = ALL_ONE;
    for (int i = 4; i < POOL_DEPTH; i++) key_pool[i] = $urandom;

    // Directed part, starting from the reset capacity of a full table.
    plan_request(lfu_pkg::ACT_GET, '0, $urandom);
    plan_request(lfu_pkg::ACT_SET, INT_MIN, INT_MAX);
    plan_request(lfu_pkg::ACT_SET, INT_MAX, INT_MIN);
    plan_request(lfu_pkg::ACT_SET, '0, '0);
    plan_request(lfu_pkg::ACT_SET, ALL_ONE, ALL_ONE);
    plan_request(lfu_pkg::ACT_GET, INT_MIN, $urandom);
    plan_request(lfu_pkg::ACT_GET, ALL_ONE, '0);
    plan_request(lfu_pkg::ACT_SET, INT_MAX, 32'h1234_5678);
    plan_request(lfu_pkg::ACT_GET, INT_MAX, ALL_ONE);
    plan_request(lfu_pkg::ACT_GET, 32'h5555_5555, $urandom);
    plan_request(lfu_pkg::ACT_SET, 32'h5555_5555, 32'hAAAA_AAAA);
    plan_request(lfu_pkg::ACT_SET, 32'hAAAA_AAAA, 32'h5555_5555);
    // Capacity below the occupancy: new keys replace among all valid entries.
    plan_capacity(5'd2);
    plan_request(lfu_pkg::ACT_SET, 32'h0F0F_0F0F, 32'd7);
    plan_request(lfu_pkg::ACT_GET, '0, $urandom);
    plan_request(lfu_pkg::ACT_SET, 32'h0F0F_0F0F, 32'd8);
    plan_request(lfu_pkg::ACT_SET, 32'h0000_0001, 32'd9);
    plan_request(lfu_pkg::ACT_GET, 32'h0F0F_0F0F, $urandom);
    // A capacity of zero behaves as one.
    plan_capacity(5'd0);
    plan_request(lfu_pkg::ACT_SET, 32'h0000_0002, 32'd1);
    plan_request(lfu_pkg::ACT_GET, 32'h0000_0002, $urandom);
    plan_request(lfu_pkg::ACT_GET, INT_MIN, $urandom);
    plan_request(lfu_pkg::ACT_SET, 32'hF0F0_F0F0, INT_MIN);

    plan_random_phase(5'd31, 20, 100);
    plan_random_phase(5'd1, 3, 60);
    plan_random_phase(5'd0, 2, 40);
    plan_random_phase(5'd5, 8, 80);
    plan_random_phase(5'd16, 24, 100);
    plan_random_phase(5'd3, 10, 80);
    plan_random_phase(5'd8, 12, 80);
    plan_random_phase(5'd10, 14, 60);
    plan_random_phase(5'd16, POOL_DEPTH, 100);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while ((request_plan.size() != 0 || start || cfg_valid || predicted_replies.size() != 0)
           && quiet_cycles < STALL_LIMIT)
      @(posedge clk);
    tail = 0;
    while (tail < TAIL_CYCLES && quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      tail++;
    end

    if (fail_count == 0 && quiet_cycles < STALL_LIMIT && predicted_replies.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
